@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the converter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define E2Q_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define E2Q_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`define E2Q_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define E2Q_ASSERT(lbl, prop, msg)
`define E2Q_ASSERT_IMP(lbl, ante, cons, msg)
`define E2Q_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/e2q_pkg.sv @@
// Types, constants and the arctangent table of the Euler-to-quaternion converter.
// No dependencies.
package e2q_pkg;

   localparam int CORDIC_STAGES = 24;
   localparam int REDUCE_LAT    = 4;
   localparam int COMBINE_LAT   = 5;
   localparam int PIPE_LAT      = REDUCE_LAT + CORDIC_STAGES + COMBINE_LAT;

   localparam logic signed [26:0] HALF_TURN_Q17    = 27'sd23592960;
   localparam logic signed [26:0] FULL_TURN_Q17    = 27'sd47185920;
   localparam logic signed [26:0] QUARTER_TURN_Q17 = 27'sd11796480;
   localparam logic signed [43:0] GAIN_Q40         = 44'sd667681662976;
   localparam logic signed [31:0] ONE_Q30          = 32'sd1073741824;

   typedef struct packed {
      logic signed [31:0] roll_deg;
      logic signed [31:0] pitch_deg;
      logic signed [31:0] yaw_deg;
   } req_type;

   typedef struct packed {
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
   } rsp_type;

   typedef struct packed {
      logic signed [43:0] x;
      logic signed [43:0] y;
      logic signed [35:0] z;
      logic               neg;
   } cordic_type;

   localparam logic signed [35:0] ATAN_LUT [11] = '{
      36'sd3373259426, 36'sd1991351318, 36'sd1052175346, 36'sd534100635,
      36'sd268086748,  36'sd134174062,  36'sd67103403,   36'sd33553749,
      36'sd16777131,   36'sd8388597,    36'sd4194303
   };

   // arctangent of 2^-idx in radians, 32 fraction bits
   function automatic logic signed [35:0] atan_q32(input logic [4:0] idx);
      logic signed [35:0] v;
      if (idx < 5'd11) begin
         v = ATAN_LUT[idx[3:0]];
      end else begin
         v = 36'sd1 <<< (6'd32 - {1'b0, idx});
      end
      return v;
   endfunction

endpackage

@@ rtl/core/e2q_reduce.sv @@
// Angle reduction: halve, wrap, fold into a quarter turn, convert to radians.
// Depends on e2q_pkg; four register stages.
module e2q_reduce (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [31:0]         angle_deg,
   output e2q_pkg::cordic_type        seed
);
   import e2q_pkg::*;

   localparam logic signed [17:0] DEG_HI = 18'sd73204;
   localparam logic signed [17:0] DEG_LO = 18'sd54346;

   logic [11:0]        u_ff, u_in;
   logic [6:0]         q_ff, q_in;
   logic [19:0]        lo_ff, lo_in;
   logic signed [24:0] m_ff, m_in;
   logic               neg2_ff, neg2_in;
   logic signed [42:0] ph_ff, ph_in, pl_ff, pl_in;
   logic               neg3_ff;
   logic signed [35:0] z_ff, z_in;
   logic               neg4_ff;

   logic [24:0]        qprod;
   logic [6:0]         rem, tmod;
   logic [5:0]         mh;
   logic signed [26:0] mm;
   logic signed [59:0] zsum;

   // quotient of the upper bits by 45 through a reciprocal
   always_comb begin
      u_in  = {~angle_deg[31], angle_deg[30:20]};
      lo_in = angle_deg[19:0];
      qprod = 25'(u_in * 13'd5826);
      q_in  = qprod[24:18];
   end

   always_comb begin
      rem  = 7'(u_ff - 12'(q_ff) * 12'd45);
      tmod = 7'(rem + 7'd22);
      mh   = (tmod >= 7'd45) ? 6'(tmod - 7'd45) : tmod[5:0];
      mm   = $signed({1'b0, mh, lo_ff});
      if (mm >= HALF_TURN_Q17) begin
         mm = mm - FULL_TURN_Q17;
      end
      neg2_in = 1'b0;
      if (mm > QUARTER_TURN_Q17) begin
         mm      = mm - HALF_TURN_Q17;
         neg2_in = 1'b1;
      end else if (mm < -QUARTER_TURN_Q17) begin
         mm      = mm + HALF_TURN_Q17;
         neg2_in = 1'b1;
      end
      m_in = 25'(mm);
   end

   always_comb begin
      ph_in = 43'(m_ff * DEG_HI);
      pl_in = 43'(m_ff * DEG_LO);
      zsum  = (60'(ph_ff) <<< 17) + 60'(pl_ff) + 60'sd8388608;
      z_in  = 36'(zsum >>> 24);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff    <= u_in;
         q_ff    <= q_in;
         lo_ff   <= lo_in;
         m_ff    <= m_in;
         neg2_ff <= neg2_in;
         ph_ff   <= ph_in;
         pl_ff   <= pl_in;
         neg3_ff <= neg2_ff;
         z_ff    <= z_in;
         neg4_ff <= neg3_ff;
      end
   end

   assign seed.x   = GAIN_Q40;
   assign seed.y   = '0;
   assign seed.z   = z_ff;
   assign seed.neg = neg4_ff;

endmodule

@@ rtl/core/e2q_cell.sv @@
// One rotation-mode CORDIC micro-rotation with its output register.
// Depends on e2q_pkg.
module e2q_cell (
   input  logic                clock,
   input  logic                en,
   input  logic [4:0]          shift,
   input  logic signed [35:0]  angle,
   input  e2q_pkg::cordic_type cin,
   output e2q_pkg::cordic_type cout
);
   import e2q_pkg::*;

   cordic_type         cell_ff, cell_in;
   logic signed [43:0] dx, dy;

   always_comb begin
      dx          = cin.y >>> shift;
      dy          = cin.x >>> shift;
      cell_in.neg = cin.neg;
      if (!cin.z[35]) begin
         cell_in.x = cin.x - dx;
         cell_in.y = cin.y + dy;
         cell_in.z = cin.z - angle;
      end else begin
         cell_in.x = cin.x + dx;
         cell_in.y = cin.y - dy;
         cell_in.z = cin.z + angle;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign cout = cell_ff;

endmodule

@@ rtl/core/e2q_combine.sv @@
// Rounds the CORDIC sine/cosine to Q30 and forms the quaternion products.
// Depends on e2q_pkg; five register stages.
module e2q_combine (
   input  logic                clock,
   input  logic                en,
   input  e2q_pkg::cordic_type roll_cs,
   input  e2q_pkg::cordic_type pitch_cs,
   input  e2q_pkg::cordic_type yaw_cs,
   output e2q_pkg::rsp_type    quat
);
   import e2q_pkg::*;

   function automatic logic signed [31:0] clamp34(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'(ONE_Q30)) begin
         r = ONE_Q30;
      end else if (v < -34'(ONE_Q30)) begin
         r = -ONE_Q30;
      end else begin
         r = 32'(v);
      end
      return r;
   endfunction

   function automatic logic signed [31:0] trig_q30(input logic signed [43:0] v,
                                                  input logic neg);
      logic signed [31:0] r;
      r = clamp34(34'((v + 44'sd512) >>> 10));
      return neg ? -r : r;
   endfunction

   function automatic logic signed [31:0] rnd_q30(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = (v + 64'sd536870912) >>> 30;
      return 32'(t);
   endfunction

   logic signed [31:0] cr_ff, sr_ff, cp_ff, sp_ff, cy_ff, sy_ff;
   logic signed [63:0] pcc_ff, pss_ff, psc_ff, pcs_ff;
   logic signed [31:0] cy2_ff, sy2_ff, cy3_ff, sy3_ff;
   logic signed [31:0] rcc_ff, rss_ff, rsc_ff, rcs_ff;
   logic signed [63:0] tw1_ff, tw2_ff, tx1_ff, tx2_ff, ty1_ff, ty2_ff, tz1_ff, tz2_ff;
   rsp_type            quat_ff, quat_in;

   always_comb begin
      quat_in.quat_w = clamp34(34'((tw1_ff + tw2_ff + 64'sd536870912) >>> 30));
      quat_in.quat_x = clamp34(34'((tx1_ff - tx2_ff + 64'sd536870912) >>> 30));
      quat_in.quat_y = clamp34(34'((ty1_ff + ty2_ff + 64'sd536870912) >>> 30));
      quat_in.quat_z = clamp34(34'((tz1_ff - tz2_ff + 64'sd536870912) >>> 30));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cr_ff  <= trig_q30(roll_cs.x, roll_cs.neg);
         sr_ff  <= trig_q30(roll_cs.y, roll_cs.neg);
         cp_ff  <= trig_q30(pitch_cs.x, pitch_cs.neg);
         sp_ff  <= trig_q30(pitch_cs.y, pitch_cs.neg);
         cy_ff  <= trig_q30(yaw_cs.x, yaw_cs.neg);
         sy_ff  <= trig_q30(yaw_cs.y, yaw_cs.neg);
         pcc_ff <= 64'(cr_ff * cp_ff);
         pss_ff <= 64'(sr_ff * sp_ff);
         psc_ff <= 64'(sr_ff * cp_ff);
         pcs_ff <= 64'(cr_ff * sp_ff);
         cy2_ff <= cy_ff;
         sy2_ff <= sy_ff;
         rcc_ff <= rnd_q30(pcc_ff);
         rss_ff <= rnd_q30(pss_ff);
         rsc_ff <= rnd_q30(psc_ff);
         rcs_ff <= rnd_q30(pcs_ff);
         cy3_ff <= cy2_ff;
         sy3_ff <= sy2_ff;
         tw1_ff <= 64'(rcc_ff * cy3_ff);
         tw2_ff <= 64'(rss_ff * sy3_ff);
         tx1_ff <= 64'(rsc_ff * cy3_ff);
         tx2_ff <= 64'(rcs_ff * sy3_ff);
         ty1_ff <= 64'(rcs_ff * cy3_ff);
         ty2_ff <= 64'(rsc_ff * sy3_ff);
         tz1_ff <= 64'(rcc_ff * sy3_ff);
         tz2_ff <= 64'(rss_ff * cy3_ff);
         quat_ff <= quat_in;
      end
   end

   assign quat = quat_ff;

endmodule

@@ rtl/core/euler_to_quaternion.sv @@
// Top level of the ZYX Euler-angle to quaternion converter.
// Depends on e2q_pkg, e2q_reduce, e2q_cell, e2q_combine and assert_macros.svh.
//
// Takes roll, pitch and yaw in degrees (signed, 16 fraction bits) and returns
// the unit quaternion w, x, y, z (signed, 30 fraction bits, clamped to +/-1).
// Every angle wraps by its exact remainder, so any input value is legal. The
// block is a single pipeline of PIPE_LAT = 4 + CORDIC_STAGES + 5 register
// stages: four for angle reduction and the degree-to-radian multiply, one
// chain of CORDIC cells per angle (one micro-rotation per cell per cycle),
// and five for rounding and the quaternion products. It takes one item per
// cycle while the pipeline advances and gives one result item per item, in
// order. The whole pipeline holds while a finished item sits at the output
// and rsp_stall is high; req_stall then rises in the same cycle.
module euler_to_quaternion (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  e2q_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output e2q_pkg::rsp_type rsp_data
);
   import e2q_pkg::*;
`include "assert_macros.svh"

   logic [PIPE_LAT-1:0] vld_ff, vld_in;
   logic                advance;
   logic                req_take;

   cordic_type chain_r [CORDIC_STAGES+1];
   cordic_type chain_p [CORDIC_STAGES+1];
   cordic_type chain_y [CORDIC_STAGES+1];

   // advance everything unless the output item is held
   assign advance   = !(vld_ff[PIPE_LAT-1] && rsp_stall);
   assign req_stall = !advance;
   assign req_take  = req_valid && advance;

   always_comb begin
      vld_in = {vld_ff[PIPE_LAT-2:0], req_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // halve, wrap and convert each angle
   e2q_reduce u_red_r (.clock(clock), .en(advance), .angle_deg(req_data.roll_deg),
                       .seed(chain_r[0]));
   e2q_reduce u_red_p (.clock(clock), .en(advance), .angle_deg(req_data.pitch_deg),
                       .seed(chain_p[0]));
   e2q_reduce u_red_y (.clock(clock), .en(advance), .angle_deg(req_data.yaw_deg),
                       .seed(chain_y[0]));

   // one row of CORDIC cells per angle
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      e2q_cell u_cell_r (.clock(clock), .en(advance), .shift(5'(i)),
                         .angle(atan_q32(5'(i))), .cin(chain_r[i]), .cout(chain_r[i+1]));
      e2q_cell u_cell_p (.clock(clock), .en(advance), .shift(5'(i)),
                         .angle(atan_q32(5'(i))), .cin(chain_p[i]), .cout(chain_p[i+1]));
      e2q_cell u_cell_y (.clock(clock), .en(advance), .shift(5'(i)),
                         .angle(atan_q32(5'(i))), .cin(chain_y[i]), .cout(chain_y[i+1]));
   end

   // round the sines and cosines and form w, x, y, z
   e2q_combine u_comb (
      .clock   (clock),
      .en      (advance),
      .roll_cs (chain_r[CORDIC_STAGES]),
      .pitch_cs(chain_p[CORDIC_STAGES]),
      .yaw_cs  (chain_y[CORDIC_STAGES]),
      .quat    (rsp_data)
   );

   assign rsp_valid = vld_ff[PIPE_LAT-1];

   `E2Q_ASSERT_NEXT(a_take_enters, req_valid && !req_stall, vld_ff[0], "accepted item lost at pipe entry")
   `E2Q_ASSERT_IMP(a_stall_match, vld_ff[PIPE_LAT-1] && rsp_stall, !advance, "pipeline moved under a held result")
   `E2Q_ASSERT_IMP(a_w_range, rsp_valid, rsp_data.quat_w <= ONE_Q30 && rsp_data.quat_w >= -ONE_Q30, "quat_w out of range")
   `E2Q_ASSERT_IMP(a_x_range, rsp_valid, rsp_data.quat_x <= ONE_Q30 && rsp_data.quat_x >= -ONE_Q30, "quat_x out of range")

endmodule

@@ bench/euler_to_quaternion_tb.sv @@
// Testbench for euler_to_quaternion: drives Euler-angle items, predicts the quaternion
// of each with a bit-exact fixed-point model of its own, and checks results in order.
// Depends on e2q_pkg and the euler_to_quaternion RTL.
module euler_to_quaternion_tb;
   import e2q_pkg::*;

   localparam longint HALF_Q17    = 64'sd23592960;
   localparam longint FULL_Q17    = 64'sd47185920;
   localparam longint QUARTER_Q17 = 64'sd11796480;
   localparam longint RAD_PER_DEG = 64'sd9595049034;
   localparam longint START_GAIN  = 64'sd2608131496 * 64'sd256;
   localparam longint UNIT_Q30    = 64'sd1073741824;
   localparam int     N_RANDOM    = 400;
   localparam int     MAX_REPORTS = 10;

   typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_type;

   // Expected quaternions, oldest first; counts mismatches.
   class quat_scoreboard;
      rsp_type pending[$];
      int      errors;

      static function longint clamp_unit(longint v);
         if (v > UNIT_Q30) return UNIT_Q30;
         if (v < -UNIT_Q30) return -UNIT_Q30;
         return v;
      endfunction

      static function longint mul_q30(longint a, longint b);
         return (a * b + (64'sd1 <<< 29)) >>> 30;
      endfunction

      // Cosine and sine (Q30) of half the angle given in Q16 degrees.
      static function void half_sin_cos(longint deg, output longint c, output longint s);
         longint m, x, y, z, step, dx, dy;
         bit     flip;
         m = deg % FULL_Q17;
         flip = 0;
         if (m < 0) m += FULL_Q17;
         if (m >= HALF_Q17) m -= FULL_Q17;
         if (m > QUARTER_Q17) begin
            m -= HALF_Q17;
            flip = 1;
         end else if (m < -QUARTER_Q17) begin
            m += HALF_Q17;
            flip = 1;
         end
         z = (m * RAD_PER_DEG + (64'sd1 <<< 23)) >>> 24;
         x = START_GAIN;
         y = 0;
         for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            step = (i < 11) ? longint'(ATAN_LUT[i]) : (64'sd1 <<< (32 - i));
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= step;
            end else begin
               x += dx;
               y -= dy;
               z += step;
            end
         end
         c = clamp_unit((x + 512) >>> 10);
         s = clamp_unit((y + 512) >>> 10);
         if (flip) begin
            c = -c;
            s = -s;
         end
      endfunction

      static function logic signed [31:0] blend(longint a, longint b, longint c,
                                                longint d, longint e, longint f, bit sub);
         longint t1, t2, sum;
         t1 = mul_q30(a, b) * c;
         t2 = mul_q30(d, e) * f;
         sum = sub ? t1 - t2 : t1 + t2;
         return 32'(clamp_unit((sum + (64'sd1 <<< 29)) >>> 30));
      endfunction

      function void note_angles(req_type r);
         longint cr, sr, cp, sp, cy, sy;
         rsp_type q;
         half_sin_cos(longint'(r.roll_deg), cr, sr);
         half_sin_cos(longint'(r.pitch_deg), cp, sp);
         half_sin_cos(longint'(r.yaw_deg), cy, sy);
         q.quat_w = blend(cr, cp, cy, sr, sp, sy, 0);
         q.quat_x = blend(sr, cp, cy, cr, sp, sy, 1);
         q.quat_y = blend(cr, sp, cy, sr, cp, sy, 0);
         q.quat_z = blend(cr, cp, sy, sr, sp, cy, 1);
         pending.push_back(q);
      endfunction

      function void check_quat(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) $display("unexpected result item %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("mismatch: w %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d (exp/act)",
                        want.quat_w, got.quat_w, want.quat_x, got.quat_x,
                        want.quat_y, got.quat_y, want.quat_z, got.quat_z);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   quat_scoreboard board = new();
   phase_type      phase = PH_FREE;
   logic           hold_go = 0;       // ask for one long receiver hold-off
   bit             hold_armed = 1;    // hold-off not yet started
   int             hold_cycles = 0;   // hold-off cycles still to run

   euler_to_quaternion DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Note accepted items and check results at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_angles(req_data);
         if (rsp_valid && !rsp_stall) board.check_quat(rsp_data);
      end
   end

   // Receiver stall: random per phase, or held for a long forced stretch.
   always @(negedge clock) begin
      if (hold_go && hold_armed) begin
         hold_armed  <= 0;
         hold_cycles <= 79;
         rsp_stall   <= 1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall   <= 1;
      end else if (phase == PH_RECV_STALL) begin
         rsp_stall <= ($urandom_range(99) < 86);
      end else if (phase == PH_BOTH) begin
         rsp_stall <= ($urandom_range(99) < 21);
      end else begin
         rsp_stall <= 0;
      end
   end

   // Offer one item; hold it until accepted. Valid stays up for a following item.
   task automatic send_angles(req_type r);
      int idle_pct;
      idle_pct = (phase == PH_SEND_IDLE) ? 86 : (phase == PH_BOTH) ? 21 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drop valid once no further item follows.
   task automatic stop_sending();
      req_valid <= 0;
   endtask

   task automatic send_triple(int r, int p, int y);
      req_type t;
      t.roll_deg  = r;
      t.pitch_deg = p;
      t.yaw_deg   = y;
      send_angles(t);
   endtask

   function automatic int rand_angle();
      case ($urandom_range(5))
         0: return $urandom();                                   // full 32-bit range
         1: return int'($urandom_range(46080)) - 23040;          // within one turn
         2: return (int'($urandom_range(16)) - 8) * 32'sd5898240; // multiples of 90 deg
         3: return (int'($urandom_range(16)) - 8) * 32'sd5898240
                   + int'($urandom_range(4)) - 2;                 // near fold points
         4: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                     : 32'h80000000 + $urandom_range(3);
         default: return int'($urandom_range(200000)) - 100000;   // small angles
      endcase
   endfunction

   task automatic wait_drained();
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: zero, extremes, quarter and half turns, fold boundaries.
      send_triple(0, 0, 0);
      send_triple(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_triple(32'h80000000, 32'h80000000, 32'h80000000);
      send_triple(32'h80000000, 32'h7fffffff, 0);
      send_triple(90 <<< 16, 0, 0);
      send_triple(0, 90 <<< 16, 0);
      send_triple(0, 0, 90 <<< 16);
      send_triple(180 <<< 16, -(180 <<< 16), 360 <<< 16);
      send_triple(720 <<< 16, -(720 <<< 16), 540 <<< 16);
      send_triple((180 <<< 16) + 1, (180 <<< 16) - 1, -(180 <<< 16) - 1);
      send_triple(-(360 <<< 16), (360 <<< 16) - 1, -(360 <<< 16) + 1);
      send_triple(45 <<< 16, 45 <<< 16, 45 <<< 16);
      send_triple(1, -1, 1);
      send_triple(-1, 1, -1);
      send_triple(0, -(90 <<< 16), 0);
      send_triple(30 <<< 16, 60 <<< 16, -(120 <<< 16));
      send_triple(32'h55555555, 32'haaaaaaaa, 32'h0000ffff);
      send_triple(32'haaaaaaaa, 32'h55555555, 32'hffff0000);

      // Long receiver hold-off while items keep coming, so the pipe backs up.
      hold_go <= 1;
      for (int i = 0; i < 50; i++) send_triple(rand_angle(), rand_angle(), rand_angle());
      stop_sending();
      wait_drained();   // sender pauses until every result is back

      for (int ph = 0; ph < 4; ph++) begin
         phase = phase_type'(ph);
         for (int i = 0; i < N_RANDOM / 4; i++)
            send_triple(rand_angle(), rand_angle(), rand_angle());
      end
      stop_sending();
      phase = PH_FREE;

      wait_drained();
      repeat (PIPE_LAT + 10) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("euler_to_quaternion test passed");
      end else begin
         $display("euler_to_quaternion test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("euler_to_quaternion test failed");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/e2q_pkg.sv
rtl/core/e2q_reduce.sv
rtl/core/e2q_cell.sv
rtl/core/e2q_combine.sv
rtl/core/euler_to_quaternion.sv
bench/euler_to_quaternion_tb.sv
